// File: rtl/midi_clock_tempo_tracker_unit_assert.svh
// ----------------------------------------------------------------------------
// MIDI clock tempo tracker assertion macros
// Property shorthands shared by the checker of the tracker.
// ----------------------------------------------------------------------------
`ifndef MIDI_CLOCK_TEMPO_TRACKER_UNIT_ASSERT_SVH
`define MIDI_CLOCK_TEMPO_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define MCTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define MCTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mctt_pkg.sv
// ----------------------------------------------------------------------------
// MIDI clock tempo tracker package
// Shared types, message codes and arithmetic constants.
// ----------------------------------------------------------------------------
package mctt_pkg;

    // MIDI status codes
    localparam logic [7:0] ST_CLOCK   = 8'hF8;
    localparam logic [7:0] ST_SONGPOS = 8'hF2;
    localparam logic [1:0] SONGPOS_BYTES = 2'd3;

    // Register map (word index on paddr[2])
    localparam logic REG_MAX_GAP = 1'b0;
    localparam int unsigned PADDR_W = 3;
    localparam logic [23:0] MAX_GAP_RESET = 24'd200000;

    localparam int unsigned POSITION_WIDTH_DEF = 32;

    // Song position scale: six ticks per MIDI beat
    localparam int unsigned SONGPOS_W = 14;
    localparam int unsigned SPTICK_W  = 17;
    localparam logic [SPTICK_W-1:0] TICKS_PER_BEAT = 17'd6;

    // floor(x / 5) == (x * RECIP_FIVE) >> 34 for any 32-bit x
    localparam logic [31:0] RECIP_FIVE = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_SHIFT = 34;

    // Tempo: 60 s * 1e6 us * 256 (interval Q8) * 256 (bpm Q8) / 24 ticks
    localparam int unsigned DIV_NUM_W = 38;
    localparam logic [DIV_NUM_W-1:0] BPM_NUMER = 38'd163840000000;
    localparam logic [23:0] BPM_MAX = 24'hFF_FFFF;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_REJECT,
        CMD_CLOCK,
        CMD_SONGPOS
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [SONGPOS_W-1:0]   beats;
        logic [31:0]            arrival;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_MUL,
        BK_AVG,
        BK_DIV,
        BK_RESULT
    } back_state_t;

endpackage

// File: rtl/mctt_front.sv
// ----------------------------------------------------------------------------
// MIDI clock tempo tracker front end
// Accepts messages and classifies them into commands for the queue.
// ----------------------------------------------------------------------------
module mctt_front (
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           status,
    input  logic [6:0]           data_low,
    input  logic [6:0]           data_high,
    input  logic [1:0]           byte_count,
    input  logic [31:0]          arrival_us,
    input  mctt_pkg::queue_stat_t q_stat,
    output logic                 push,
    output mctt_pkg::cmd_t       cmd
);
    import mctt_pkg::*;

    cmd_kind_t kind;

    always_comb
    begin
        priority if (status == ST_CLOCK)
        begin
            kind = CMD_CLOCK;
        end
        else if (status == ST_SONGPOS && byte_count >= SONGPOS_BYTES)
        begin
            kind = CMD_SONGPOS;
        end
        else
        begin
            kind = CMD_REJECT;
        end
    end

    assign cmd.kind    = kind;
    assign cmd.beats   = {data_high, data_low};
    assign cmd.arrival = arrival_us;

    // hold the producer while the queue has no room
    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;

endmodule

// File: rtl/mctt_queue.sv
// ----------------------------------------------------------------------------
// MIDI clock tempo tracker command queue
// Short FIFO that decouples the front end from the execution back end.
// ----------------------------------------------------------------------------
module mctt_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mctt_pkg::cmd_t        wr_cmd,
    input  logic                  pop,
    output mctt_pkg::cmd_t        rd_cmd,
    output mctt_pkg::queue_stat_t q_stat
);
    import mctt_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;
    assign rd_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// File: rtl/mctt_div.sv
// ----------------------------------------------------------------------------
// MIDI clock tempo tracker tempo divider
// Restoring divider, one quotient bit per cycle, of the fixed tempo numerator.
// ----------------------------------------------------------------------------
module mctt_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [31:0]                     divisor,
    output logic                            done,
    output logic [mctt_pkg::DIV_NUM_W-1:0]  quotient
);
    import mctt_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_NUM_W);

    logic [31:0]          div_reg;
    logic [31:0]          rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [32:0]          rem_sh;
    logic [32:0]          rem_sub;
    logic                 fits;

    // shift in the next numerator bit, subtract when the divisor fits
    assign rem_sh   = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign rem_sub  = rem_sh - {1'b0, div_reg};
    assign fits     = (rem_sh >= {1'b0, div_reg});
    assign rem_next = fits ? rem_sub[31:0] : rem_sh[31:0];
    assign quo_next = {quo_reg[DIV_NUM_W-2:0], fits};

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(DIV_NUM_W - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= BPM_NUMER;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

// File: rtl/mctt_back.sv
// ----------------------------------------------------------------------------
// MIDI clock tempo tracker back end
// Executes queued commands, keeps position and interval average, forms tempo.
// ----------------------------------------------------------------------------
module mctt_back #(
    parameter int unsigned POSITION_WIDTH = mctt_pkg::POSITION_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [23:0]           max_gap,
    input  mctt_pkg::cmd_t        head,
    input  mctt_pkg::queue_stat_t q_stat,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  accepted,
    output logic [31:0]           position_ticks,
    output logic [31:0]           interval_q8,
    output logic [23:0]           bpm_q8
);
    import mctt_pkg::*;

    back_state_t state_reg, state_next;

    cmd_t                      cmd_reg;
    logic [POSITION_WIDTH-1:0] pos_reg;
    logic [31:0]               avg_reg;
    logic [31:0]               last_reg;
    logic                      seen_reg;
    logic [23:0]               bpm_reg;
    logic [31:0]               mag_reg;
    logic                      neg_reg;
    logic [63:0]               prod_reg;

    logic                      out_valid_reg;
    logic                      acc_out_reg;
    logic [31:0]               pos_out_reg;
    logic [31:0]               avg_out_reg;
    logic [23:0]               bpm_out_reg;

    logic                      div_start;
    logic                      div_done;
    logic [DIV_NUM_W-1:0]      div_quo;
    logic                      out_load;

    logic [31:0]               gap;
    logic [31:0]               gap_q8;
    logic                      averaging;
    logic [31:0]               fifth;
    logic [31:0]               avg_new;
    logic [SPTICK_W-1:0]       sp_ticks;
    logic [23:0]               bpm_sat;

    assign gap       = cmd_reg.arrival - last_reg;
    assign gap_q8    = {gap[23:0], 8'd0};
    assign averaging = seen_reg && (gap < {8'd0, max_gap});
    assign fifth     = 32'(prod_reg[63:RECIP_SHIFT]);
    assign avg_new   = neg_reg ? (avg_reg - fifth) : (avg_reg + fifth);
    assign sp_ticks  = SPTICK_W'(cmd_reg.beats) * TICKS_PER_BEAT;
    assign bpm_sat   = (|div_quo[DIV_NUM_W-1:24]) ? BPM_MAX : div_quo[23:0];

    mctt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (avg_new),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (cmd_reg.kind == CMD_CLOCK && averaging)
                begin
                    state_next = BK_MUL;
                end
                else
                begin
                    state_next = BK_RESULT;
                end
            end
            BK_MUL:
            begin
                state_next = BK_AVG;
            end
            BK_AVG:
            begin
                state_next = (avg_new == '0) ? BK_RESULT : BK_DIV;
            end
            BK_DIV:
            begin
                if (div_done)
                begin
                    state_next = BK_RESULT;
                end
            end
            BK_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            BK_IDLE:   pop       = !q_stat.empty;
            BK_AVG:    div_start = (avg_new != '0);
            BK_RESULT: out_load  = !out_valid_reg || !out_stall;
            default:   pop       = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            pos_reg       <= '0;
            avg_reg       <= '0;
            last_reg      <= '0;
            seen_reg      <= 1'b0;
            bpm_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
            unique case (state_reg)
                BK_EXEC:
                begin
                    if (cmd_reg.kind == CMD_CLOCK)
                    begin
                        pos_reg  <= pos_reg + POSITION_WIDTH'(1);
                        last_reg <= cmd_reg.arrival;
                        seen_reg <= 1'b1;
                    end
                    else if (cmd_reg.kind == CMD_SONGPOS)
                    begin
                        pos_reg <= POSITION_WIDTH'(sp_ticks);
                    end
                end
                BK_AVG:
                begin
                    avg_reg <= avg_new;
                    if (avg_new == '0)
                    begin
                        bpm_reg <= '0;
                    end
                end
                BK_DIV:
                begin
                    if (div_done)
                    begin
                        bpm_reg <= bpm_sat;
                    end
                end
                default:
                begin
                    bpm_reg <= bpm_reg;
                end
            endcase
        end
    end

    // payload path: command capture, average step, result register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head;
        end
        if (state_reg == BK_EXEC)
        begin
            neg_reg <= (gap_q8 < avg_reg);
            mag_reg <= (gap_q8 < avg_reg) ? (avg_reg - gap_q8) : (gap_q8 - avg_reg);
        end
        if (state_reg == BK_MUL)
        begin
            prod_reg <= mag_reg * RECIP_FIVE;
        end
        if (out_load)
        begin
            acc_out_reg <= (cmd_reg.kind != CMD_REJECT);
            pos_out_reg <= 32'(pos_reg);
            avg_out_reg <= avg_reg;
            bpm_out_reg <= bpm_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign accepted       = acc_out_reg;
    assign position_ticks = pos_out_reg;
    assign interval_q8    = avg_out_reg;
    assign bpm_q8         = bpm_out_reg;

endmodule

// File: rtl/midi_clock_tempo_tracker_unit.sv
// ----------------------------------------------------------------------------
// MIDI clock tempo tracker
// Song position counter and tick-interval average with a Q16.8 tempo readout.
// ----------------------------------------------------------------------------
// Each input item is one MIDI message and yields exactly one result. A timing
// clock advances the position by one tick and, when a previous clock exists
// and the gap is below max_gap_us, moves the Q24.8 interval average one fifth
// of the way toward the new gap. A complete song position pointer loads six
// ticks per beat. Anything else is rejected and only reports the state.
// Messages land in a two-entry command queue, so the input keeps flowing
// while a result waits on out_stall, until the queue is full. A clock that
// moves the average to a nonzero value passes through the back end steps
// capture, execute, multiply by the reciprocal of five, update, 38-step
// restoring tempo divide and result. A clock whose average lands on zero
// skips the divide; every other message goes from execute to result.
// A stalled result holds the back end in its result step. The divider
// sets the rate. max_gap_us lives at byte address 0 of the APB port; write
// it only while the tracker is idle.
module midi_clock_tempo_tracker_unit #(
    parameter int unsigned POSITION_WIDTH = mctt_pkg::POSITION_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // message channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     status,
    input  logic [6:0]                     data_low,
    input  logic [6:0]                     data_high,
    input  logic [1:0]                     byte_count,
    input  logic [31:0]                    arrival_us,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           accepted,
    output logic [31:0]                    position_ticks,
    output logic [31:0]                    interval_q8,
    output logic [23:0]                    bpm_q8,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mctt_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import mctt_pkg::*;

    logic [23:0] max_gap_reg;
    logic        cfg_write;

    cmd_t        front_cmd;
    cmd_t        head_cmd;
    queue_stat_t q_stat;
    logic        push;
    logic        pop;

    // Config register: no wait states, word index on paddr[2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MAX_GAP);
    assign prdata    = (paddr[2] == REG_MAX_GAP) ? {8'd0, max_gap_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_gap_reg <= MAX_GAP_RESET;
        end
        else if (cfg_write)
        begin
            max_gap_reg <= pwdata[23:0];
        end
    end

    // Front: classify the message and enqueue it
    mctt_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .status     (status),
        .data_low   (data_low),
        .data_high  (data_high),
        .byte_count (byte_count),
        .arrival_us (arrival_us),
        .q_stat     (q_stat),
        .push       (push),
        .cmd        (front_cmd)
    );

    // Queue: lets the front take messages while the back is busy
    mctt_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (front_cmd),
        .pop    (pop),
        .rd_cmd (head_cmd),
        .q_stat (q_stat)
    );

    // Back: update state, average and tempo, drive the result register
    mctt_back #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .max_gap        (max_gap_reg),
        .head           (head_cmd),
        .q_stat         (q_stat),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accepted       (accepted),
        .position_ticks (position_ticks),
        .interval_q8    (interval_q8),
        .bpm_q8         (bpm_q8)
    );

endmodule

// File: rtl/mctt_checker.sv
// ----------------------------------------------------------------------------
// MIDI clock tempo tracker checker
// Port-level properties of the tracker, bound onto the top level.
// ----------------------------------------------------------------------------
`include "midi_clock_tempo_tracker_unit_assert.svh"

module mctt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic                           accepted,
    input logic [31:0]                    position_ticks,
    input logic [31:0]                    interval_q8,
    input logic [23:0]                    bpm_q8,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [mctt_pkg::PADDR_W-1:0]   paddr,
    input logic [31:0]                    pwdata,
    input logic [31:0]                    prdata,
    input logic                           pready
);
    import mctt_pkg::*;

    // a stalled result holds
    `MCTT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(accepted) && $stable(position_ticks)
        && $stable(interval_q8) && $stable(bpm_q8), "stalled result changed")

    // zero interval reads as zero tempo
    `MCTT_ASSERT_IMP(a_bpm_zero, clk, rst_n, out_valid && interval_q8 == 32'd0,
        bpm_q8 == 24'd0, "tempo not zero for zero interval")

    // very short intervals saturate the tempo
    `MCTT_ASSERT_IMP(a_bpm_sat, clk, rst_n,
        out_valid && interval_q8 != 32'd0 && interval_q8 <= 32'd9765,
        bpm_q8 == BPM_MAX, "tempo not saturated")

    // a max gap write reads back on the next cycle
    `MCTT_ASSERT_NXT(a_cfg_readback, clk, rst_n,
        psel && penable && pwrite && pready && paddr == 3'd0,
        paddr != 3'd0 || prdata == {8'd0, $past(pwdata[23:0])}, "max gap readback mismatch")

endmodule

bind midi_clock_tempo_tracker_unit mctt_checker u_mctt_checker (.*);

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI clock tempo tracker testbench
// Drives MIDI messages into the tracker and checks every result against a
// predictor. The predictor keeps its own position, averaged interval and
// last-clock time.
// ----------------------------------------------------------------------------
// The run starts with a table of directed requests at the reset gap limit. It
// covers field extremes, short and full song positions, the first clock, a
// wrapped arrival time, a zero gap, gaps right at the limit, tempo
// saturation, and a shrinking average. Random phases follow, each under its
// own max_gap_us setting: 0xFFFFFF, 1, 0, a random value and the reset
// value. Most random requests are clocks with a steady, jittered tempo. Song
// positions, broken song positions, odd gaps and foreign status bytes are
// mixed in. Both sides idle at random. One phase holds the result side off
// long enough to back the tracker up, and the last phase runs with no idling.
// ----------------------------------------------------------------------------
module tb_top;

    import mctt_pkg::*;

    // Other status bytes used by the directed table
    localparam logic [7:0] ST_NULL      = 8'h00;
    localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
    localparam logic [7:0] ST_START     = 8'hFA;
    localparam logic [7:0] ST_SYS_RESET = 8'hFF;

    localparam logic [PADDR_W-1:0] GAP_ADDR = {REG_MAX_GAP, 2'b00};

    // 60 s * 1e6 us * 256 * 256 / 24 ticks per quarter note
    localparam longint unsigned TEMPO_NUMER = 64'd163840000000;
    localparam logic [23:0]     TEMPO_SAT   = 24'hFF_FFFF;

    localparam int unsigned IDLE_PCT     = 27;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PAUSE_CYCLES = 64;
    localparam int unsigned DIR_ROWS     = 24;

    typedef struct packed {
        logic [7:0]  status;
        logic [6:0]  dlo;
        logic [6:0]  dhi;
        logic [1:0]  cnt;
        logic [31:0] arrival;
    } midi_msg_t;

    typedef struct packed {
        logic        acc;
        logic [31:0] pos;
        logic [31:0] iv;
        logic [23:0] bpm;
    } tempo_res_t;

    typedef struct packed {
        midi_msg_t  msg;
        logic       fixed;
        tempo_res_t res;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  status;
    logic [6:0]  data_low;
    logic [6:0]  data_high;
    logic [1:0]  byte_count;
    logic [31:0] arrival_us;
    logic        out_valid;
    logic        out_stall;
    logic        accepted;
    logic [31:0] position_ticks;
    logic [31:0] interval_q8;
    logic [23:0] bpm_q8;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Expected result travels with the request when the table types it in
    logic        drv_fixed;
    tempo_res_t  drv_res;

    // Predictor state
    logic [31:0] tick_pos;
    logic [31:0] avg_iv;
    logic [31:0] last_clock_us;
    logic        clock_seen;
    logic [23:0] gap_limit;

    tempo_res_t  tempo_due_q [$];
    tempo_res_t  pred;
    tempo_res_t  due;

    // Random tempo generator state
    logic [31:0] t_now;
    int unsigned base_gap;
    int unsigned rand_limit;

    bit idle_en  = 1'b1;
    bit hold_arm = 1'b0;

    int unsigned n_err;
    int unsigned n_clock;
    int unsigned n_avg;
    int unsigned n_songpos;
    int unsigned n_reject;
    int unsigned n_results;
    int unsigned n_sat;

    // Directed requests: the typed-in rows are reset state, extremes and
    // cases that need no arithmetic; the rest go through the predictor.
    dir_row_t dir_tab [DIR_ROWS] = '{
        // reset state with the lowest data fields, then a foreign status, all ones
        '{'{ST_NULL, 7'h00, 7'h00, 2'd1, 32'h0000_0000}, 1'b1,
          '{1'b0, 32'd0, 32'd0, 24'd0}},
        '{'{ST_SYS_RESET, 7'h7F, 7'h7F, 2'd3, 32'hFFFF_FFFF}, 1'b1,
          '{1'b0, 32'd0, 32'd0, 24'd0}},
        // highest song position: 16383 beats, six ticks each
        '{'{ST_SONGPOS, 7'h7F, 7'h7F, 2'd3, 32'h0000_0000}, 1'b1,
          '{1'b1, 32'd98298, 32'd0, 24'd0}},
        // short song positions, byte count zero among them, change nothing
        '{'{ST_SONGPOS, 7'h7F, 7'h7F, 2'd2, 32'h0000_0000}, 1'b1,
          '{1'b0, 32'd98298, 32'd0, 24'd0}},
        '{'{ST_SONGPOS, 7'h00, 7'h00, 2'd0, 32'h0000_0000}, 1'b1,
          '{1'b0, 32'd98298, 32'd0, 24'd0}},
        '{'{ST_SONGPOS, 7'h55, 7'h2A, 2'd1, 32'h0000_0000}, 1'b1,
          '{1'b0, 32'd98298, 32'd0, 24'd0}},
        // first clock: tick only, average untouched
        '{'{ST_CLOCK, 7'h00, 7'h00, 2'd1, 32'hFFFF_FFF0}, 1'b1,
          '{1'b1, 32'd98299, 32'd0, 24'd0}},
        // arrival wraps, gap of 32 us: 8192 / 5, tempo saturates
        '{'{ST_CLOCK, 7'h00, 7'h00, 2'd1, 32'h0000_0010}, 1'b0, '0},
        // song position zero
        '{'{ST_SONGPOS, 7'h00, 7'h00, 2'd3, 32'h0000_0000}, 1'b0, '0},
        // zero gap pulls the average down, quotient truncated toward zero
        '{'{ST_CLOCK, 7'h7F, 7'h7F, 2'd0, 32'h0000_0010}, 1'b0, '0},
        // timing messages at a steady 120 BPM
        '{'{ST_CLOCK, 7'h15, 7'h6A, 2'd3, 32'd20849}, 1'b0, '0},
        '{'{ST_CLOCK, 7'h00, 7'h00, 2'd2, 32'd41682}, 1'b0, '0},
        '{'{ST_CLOCK, 7'h00, 7'h00, 2'd1, 32'd62515}, 1'b0, '0},
        '{'{ST_CLOCK, 7'h00, 7'h00, 2'd1, 32'd83348}, 1'b0, '0},
        '{'{ST_CLOCK, 7'h00, 7'h00, 2'd1, 32'd104181}, 1'b0, '0},
        // gap equal to the limit is ignored, one below is averaged
        '{'{ST_CLOCK, 7'h00, 7'h00, 2'd1, 32'd304181}, 1'b0, '0},
        '{'{ST_CLOCK, 7'h00, 7'h00, 2'd1, 32'd504180}, 1'b0, '0},
        '{'{ST_START, 7'h00, 7'h00, 2'd1, 32'h0000_0000}, 1'b0, '0},
        // huge gap is ignored
        '{'{ST_CLOCK, 7'h00, 7'h00, 2'd1, 32'h8000_0000}, 1'b0, '0},
        '{'{ST_SONGPOS, 7'h2A, 7'h55, 2'd3, 32'h0000_0000}, 1'b0, '0},
        // short gap after a long average: negative move
        '{'{ST_CLOCK, 7'h00, 7'h00, 2'd1, 32'h8000_0064}, 1'b0, '0},
        '{'{ST_NOTE_OFF, 7'h7F, 7'h00, 2'd3, 32'h8000_0064}, 1'b0, '0},
        '{'{ST_CLOCK, 7'h00, 7'h00, 2'd1, 32'h8000_0064}, 1'b0, '0},
        '{'{ST_CLOCK, 7'h00, 7'h00, 2'd1, 32'h8000_5200}, 1'b0, '0}
    };

    midi_clock_tempo_tracker_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .status         (status),
        .data_low       (data_low),
        .data_high      (data_high),
        .byte_count     (byte_count),
        .arrival_us     (arrival_us),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accepted       (accepted),
        .position_ticks (position_ticks),
        .interval_q8    (interval_q8),
        .bpm_q8         (bpm_q8),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Tempo readout: Q16.8 quarter notes per minute from a Q24.8 interval
    function automatic logic [23:0] tempo_of(input logic [31:0] iv);
        longint unsigned q;
        if (iv == 32'd0)
            return 24'd0;
        q = TEMPO_NUMER / {32'd0, iv};
        if (q > {40'd0, TEMPO_SAT})
            return TEMPO_SAT;
        return q[23:0];
    endfunction

    // Apply one message to the predicted tracker state and report the result
    function automatic tempo_res_t advance_tracker(input midi_msg_t m);
        tempo_res_t  r;
        logic [31:0] gap;
        longint      delta;
        longint      nv;
        r.acc = 1'b0;
        if (m.status == ST_CLOCK)
        begin
            r.acc = 1'b1;
            n_clock++;
            gap = m.arrival - last_clock_us;
            tick_pos = tick_pos + 32'd1;
            // move one fifth of the way toward the new gap
            if (clock_seen && gap < {8'd0, gap_limit})
            begin
                delta = longint'({32'd0, gap}) * 256 - longint'({32'd0, avg_iv});
                nv = longint'({32'd0, avg_iv}) + delta / 5;
                avg_iv = nv[31:0];
                n_avg++;
            end
            last_clock_us = m.arrival;
            clock_seen = 1'b1;
        end
        else if (m.status == ST_SONGPOS && m.cnt >= SONGPOS_BYTES)
        begin
            r.acc = 1'b1;
            n_songpos++;
            tick_pos = {18'd0, m.dhi, m.dlo} * 32'd6;
        end
        else
        begin
            n_reject++;
        end
        r.pos = tick_pos;
        r.iv  = avg_iv;
        r.bpm = tempo_of(avg_iv);
        return r;
    endfunction

    // Random message: mostly clocks at a drifting tempo, plus song positions,
    // broken song positions and foreign status bytes
    function automatic midi_msg_t next_midi_msg();
        midi_msg_t   m;
        int unsigned pick;
        int unsigned g;
        m.dlo     = 7'($urandom_range(127));
        m.dhi     = 7'($urandom_range(127));
        m.cnt     = 2'($urandom_range(3));
        m.arrival = $urandom();
        pick = $urandom_range(99);
        if (pick < 72)
        begin
            m.status = ST_CLOCK;
            if ($urandom_range(39) == 0)
                base_gap = $urandom_range(60000, 400);
            pick = $urandom_range(99);
            if (pick < 70)
                g = base_gap - base_gap / 16 + $urandom_range(base_gap / 8);
            else if (pick < 80)
                g = {8'd0, gap_limit} + $urandom_range(2) - 1;
            else if (pick < 88)
                g = $urandom_range(3);
            else if (pick < 95)
                g = $urandom_range({8'd0, gap_limit});
            else
                g = $urandom();
            t_now     = t_now + g;
            m.arrival = t_now;
        end
        else if (pick < 80)
        begin
            m.status = ST_SONGPOS;
            m.cnt    = SONGPOS_BYTES;
        end
        else if (pick < 86)
        begin
            m.status = ST_SONGPOS;
            m.cnt    = 2'($urandom_range(2));
        end
        else
        begin
            m.status = 8'($urandom_range(255));
        end
        return m;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] e,
                               input logic [31:0] a);
        if (a !== e)
        begin
            $display("%0t %s: expected %0h, got %0h", $time, fname, e, a);
            n_err++;
        end
    endtask

    // Offer one request; hold it until the tracker takes it
    task automatic send_msg(input midi_msg_t m, input logic fixed,
                            input tempo_res_t r);
        while (idle_en && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        status     <= m.status;
        data_low   <= m.dlo;
        data_high  <= m.dhi;
        byte_count <= m.cnt;
        arrival_us <= m.arrival;
        drv_fixed  <= fixed;
        drv_res    <= r;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid and wait until every expected result is back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tempo_due_q.size() != 0)
            @(posedge clk);
        repeat (PAUSE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the write lands at the access edge
    task automatic write_max_gap(input logic [23:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= GAP_ADDR;
        pwdata  <= {8'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        gap_limit  = v;
    endtask

    task automatic run_phase(input logic [23:0] limit, input int unsigned n_msgs);
        write_max_gap(limit);
        repeat (n_msgs) send_msg(next_midi_msg(), 1'b0, '0);
        settle();
    endtask

    // Predict at acceptance, check at delivery
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            pred = advance_tracker('{status, data_low, data_high, byte_count,
                                     arrival_us});
            if (drv_fixed)
                pred = drv_res;
            tempo_due_q.push_back(pred);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (tempo_due_q.size() == 0)
            begin
                $display("%0t result with no request waiting: %0h %0h %0h %0h",
                         $time, accepted, position_ticks, interval_q8, bpm_q8);
                n_err++;
            end
            else
            begin
                due = tempo_due_q.pop_front();
                check_field("accepted", {31'd0, due.acc}, {31'd0, accepted});
                check_field("position_ticks", due.pos, position_ticks);
                check_field("interval_q8", due.iv, interval_q8);
                check_field("bpm_q8", {8'd0, due.bpm}, {8'd0, bpm_q8});
                if (bpm_q8 == TEMPO_SAT)
                    n_sat++;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off once armed
    initial
    begin : rx_side
        int unsigned hold_left;
        bit          hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_arm && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        status     <= 8'd0;
        data_low   <= 7'd0;
        data_high  <= 7'd0;
        byte_count <= 2'd0;
        arrival_us <= 32'd0;
        drv_fixed  <= 1'b0;
        drv_res    <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= 32'd0;
        tick_pos      = 32'd0;
        avg_iv        = 32'd0;
        last_clock_us = 32'd0;
        clock_seen    = 1'b0;
        gap_limit     = MAX_GAP_RESET;
        n_err = 0;
        n_clock = 0;
        n_avg = 0;
        n_songpos = 0;
        n_reject = 0;
        n_results = 0;
        n_sat = 0;
        t_now      = $urandom();
        base_gap   = 20833;
        rand_limit = $urandom_range(300000, 20000);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset gap limit
        foreach (dir_tab[i])
            send_msg(dir_tab[i].msg, dir_tab[i].fixed, dir_tab[i].res);
        settle();

        run_phase(24'hFF_FFFF, 200);
        run_phase(24'd1, 110);
        run_phase(24'd0, 80);

        // hold the result side off while requests keep coming
        hold_arm <= 1'b1;
        run_phase(rand_limit[23:0], 200);

        // long stretch with no idling on either side
        idle_en <= 1'b0;
        run_phase(MAX_GAP_RESET, 280);

        $display("covered %0d requests: %0d clocks (%0d averaged), %0d song positions,",
                 n_clock + n_songpos + n_reject, n_clock, n_avg, n_songpos);
        $display("%0d rejected; gap limits 0, 1, %0d, 200000, 16777215; %0d results, %0d saturated",
                 n_reject, rand_limit, n_results, n_sat);
        if (n_err == 0)
            $display("midi_clock_tempo_tracker_unit: match");
        else
            $display("midi_clock_tempo_tracker_unit: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("run timed out with %0d results outstanding", tempo_due_q.size());
        $display("midi_clock_tempo_tracker_unit: mismatch");
        $finish;
    end

endmodule
